// ----- hdl/qmh_pkg.sv -----
// Package for the queued mutex with handoff.
// Request and result structs, command and status codes, queue sizing.
// Depends on nothing.
`default_nettype none

package qmh_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TOKEN_BITS  = 16;

    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int TOKEN_W  = 16;
    localparam int COUNT_W  = 5;
    // only the low bits that survive both the token mask and the result width
    localparam int STORE_W  = (TOKEN_BITS < TOKEN_W) ? TOKEN_BITS : TOKEN_W;

    typedef enum logic [1:0] {
        CMD_LOCK    = 2'd0,
        CMD_UNLOCK  = 2'd1,
        CMD_DESTROY = 2'd2
    } qmh_cmd_t;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_FREED   = 3'd3,
        ST_HANDOFF = 3'd4,
        ST_CLEARED = 3'd5
    } qmh_status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [TOKEN_W-1:0] requester_token;
    } qmh_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               woken_valid;
        logic [TOKEN_W-1:0] woken_token;
        logic [COUNT_W-1:0] waiter_count;
    } qmh_rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } qmh_q_ctrl_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count_next;
    } qmh_q_stat_t;

    function automatic logic [COUNT_W-1:0] to_count5(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] ext;
        ext = (CNT_W + COUNT_W)'(c);
        return ext[COUNT_W-1:0];
    endfunction

    function automatic logic [STORE_W-1:0] to_store(input logic [TOKEN_W-1:0] t);
        return t[STORE_W-1:0];
    endfunction

    function automatic logic [TOKEN_W-1:0] from_store(input logic [STORE_W-1:0] s);
        logic [STORE_W+TOKEN_W-1:0] ext;
        ext = (STORE_W + TOKEN_W)'(s);
        return ext[TOKEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/qmh_queue.sv -----
// Waiter FIFO of the queued mutex: token store, head and tail pointers, count.
// Depends on qmh_pkg.
`default_nettype none

module qmh_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire qmh_pkg::qmh_q_ctrl_t    ctrl,
    input  wire [qmh_pkg::STORE_W-1:0]   push_token,
    output logic [qmh_pkg::STORE_W-1:0]  head_token,
    output qmh_pkg::qmh_q_stat_t         stat
);
    import qmh_pkg::*;

    logic [STORE_W-1:0] store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            store_reg[tail_reg] <= push_token;
        end
    end

    assign head_token      = store_reg[head_reg];
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.count_next = count_next;

endmodule

`default_nettype wire

// ----- hdl/queued_mutex_handoff.sv -----
// Top level of the queued mutex with handoff: request register, lock logic,
// result register. Depends on qmh_pkg and qmh_queue.
//
// Usage
//   req channel : valid/ready; req carries command and requester_token.
//   rsp channel : valid/ready; rsp carries status, woken token, waiter count.
//   Every lock, unlock or destroy request gives exactly one result; the
//   unused command code is consumed and gives none.
//   Path: the request register loads at acceptance, and the result register
//   loads from it once it is empty or its result is being taken.
//   Throughput: one request per cycle if unstalled; the single pass from the
//   request register through flag and queue ends to result register sets it.
//   Reset: mutex free, queue empty, both registers empty. Token store
//   contents are not cleared.
//   Stall: a result not taken is held; one more request is taken into the
//   request register, after which req_ready drops until rsp_ready returns.
`default_nettype none

module queued_mutex_handoff (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_ready,
    input  wire qmh_pkg::qmh_req_t  req,
    output logic                    rsp_valid,
    input  wire                     rsp_ready,
    output qmh_pkg::qmh_rsp_t       rsp
);
    import qmh_pkg::*;

    logic         in_valid_reg;
    qmh_req_t     in_reg;
    logic         held_reg, held_next;
    logic         out_valid_reg;
    qmh_rsp_t     out_reg, out_next;
    logic         has_result;
    logic         advance;
    qmh_q_ctrl_t  q_ctrl;
    qmh_q_stat_t  q_stat;
    logic [STORE_W-1:0] head_token;

    always_comb
    begin
        q_ctrl     = '0;
        held_next  = held_reg;
        has_result = 1'b1;
        out_next   = '0;
        case (in_reg.command)
            CMD_LOCK:
            begin
                if (!held_reg)
                begin
                    held_next       = 1'b1;
                    out_next.status = ST_GRANTED;
                end
                else if (q_stat.full)
                begin
                    out_next.status = ST_FULL;
                end
                else
                begin
                    q_ctrl.push     = advance;
                    out_next.status = ST_QUEUED;
                end
            end
            CMD_UNLOCK:
            begin
                if (!q_stat.empty)
                begin
                    q_ctrl.pop           = advance;
                    held_next            = 1'b1;
                    out_next.status      = ST_HANDOFF;
                    out_next.woken_valid = 1'b1;
                    out_next.woken_token = from_store(head_token);
                end
                else
                begin
                    held_next       = 1'b0;
                    out_next.status = ST_FREED;
                end
            end
            CMD_DESTROY:
            begin
                q_ctrl.clear    = advance;
                held_next       = 1'b0;
                out_next.status = ST_CLEARED;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
        out_next.waiter_count = to_count5(q_stat.count_next);
    end

    assign advance   = in_valid_reg && (!has_result || !out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    qmh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (q_ctrl),
        .push_token (to_store(in_reg.requester_token)),
        .head_token (head_token),
        .stat       (q_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_reg <= req;
        end
        if (advance && has_result)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // woken token reported only on a handoff
    a_woken_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.woken_valid == (rsp.status == ST_HANDOFF)))
        else $error("woken_valid disagrees with handoff status");

    a_queued_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_QUEUED) |-> (rsp.waiter_count != '0))
        else $error("queued request left an empty queue");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL)
        |-> (rsp.waiter_count == to_count5(CNT_W'(QUEUE_DEPTH))))
        else $error("rejection with queue not full");

    a_cleared_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_CLEARED) |-> (rsp.waiter_count == '0))
        else $error("destroy left waiters");

    a_waiters_need_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result) |=> (held_reg || q_stat.empty))
        else $error("waiters queued on a free mutex");

endmodule

`default_nettype wire
